/* rtl/core/onp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onp_pkg
// Shared widths, pipeline depth, stage types and the snorm16 result
// formatting for the octahedral normal/tangent packer.
// ----------------------------------------------------------------------------
package onp_pkg;

    // Input component width.
    localparam int IN_BITS = 16;
    // L1 magnitude of three components fits one bit more than a component.
    localparam int MAG_W = IN_BITS + 1;
    // 2 * 32767 = 2^SCALE_W - 2: the numerator scale is a shift and a subtract.
    localparam int SCALE_W = 16;
    // Quotient bits: the ratio times 32767 never exceeds 32767.
    localparam int Q_W = 15;
    localparam int OUT_W = 16;
    // Dividend 65534*num + m, divisor 2*m, partial remainder below the divisor.
    localparam int N_W = MAG_W + SCALE_W;
    localparam int R_W = N_W - Q_W;
    localparam int D_W = MAG_W + 1;

    // Pipeline: vector setup, dividend setup, one stage per quotient bit.
    localparam int PREP_STAGES = 1;
    localparam int LANE_STAGES = Q_W + 1;
    localparam int NSTG = PREP_STAGES + LANE_STAGES;

    // Per-vector setup results.
    typedef struct packed {
        logic [MAG_W-1:0] m;
        logic [MAG_W-1:0] num_x;
        logic [MAG_W-1:0] num_y;
        logic             sx;
        logic             sy;
        logic             zero;
    } vec_prep_t;

    // What one divider lane starts from.
    typedef struct packed {
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] m;
        logic             neg;
        logic             zero;
    } lane_in_t;

    // What one divider lane finds.
    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           neg;
        logic           zero;
    } lane_res_t;

    // Stage load enables shared by all lanes, plus the output register load.
    typedef struct packed {
        logic [NSTG-1:0] en;
        logic            out_load;
    } pipe_ctl_t;

    // Apply sign and zero-vector rule to a lane quotient.
    function automatic logic [OUT_W-1:0] snorm_value(lane_res_t r);
        logic [OUT_W-1:0] mag;
        logic [OUT_W-1:0] result;
        mag = OUT_W'(r.q);
        if (r.zero) begin
            result = '0;
        end else if (r.neg) begin
            result = ~mag + 1'b1;
        end else begin
            result = mag;
        end
        return result;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/onp_vec_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onp_vec_prep
// Splits one vector into signs and magnitudes, forms the L1 magnitude and
// the folded or plain numerators, and registers them.
// ----------------------------------------------------------------------------
module onp_vec_prep (
    input  wire logic                         aclk,
    input  wire onp_pkg::pipe_ctl_t           ctl,
    input  wire logic [onp_pkg::IN_BITS-1:0]  comp_x,
    input  wire logic [onp_pkg::IN_BITS-1:0]  comp_y,
    input  wire logic [onp_pkg::IN_BITS-1:0]  comp_z,
    output onp_pkg::vec_prep_t                prep
);
    import onp_pkg::*;

    logic [IN_BITS-1:0] ax;
    logic [IN_BITS-1:0] ay;
    logic [IN_BITS-1:0] az;
    vec_prep_t          prep_next;
    vec_prep_t          prep_reg;

    // Absolute values; the most negative code maps to 2^(IN_BITS-1)
    always_comb begin
        ax = comp_x[IN_BITS-1] ? (~comp_x + 1'b1) : comp_x;
        ay = comp_y[IN_BITS-1] ? (~comp_y + 1'b1) : comp_y;
        az = comp_z[IN_BITS-1] ? (~comp_z + 1'b1) : comp_z;
    end

    // Magnitude and numerators; negative z folds across the diagonals
    always_comb begin
        prep_next.m    = MAG_W'(ax) + MAG_W'(ay) + MAG_W'(az);
        prep_next.sx   = comp_x[IN_BITS-1];
        prep_next.sy   = comp_y[IN_BITS-1];
        prep_next.zero = (prep_next.m == '0);
        if (comp_z[IN_BITS-1]) begin
            prep_next.num_x = prep_next.m - MAG_W'(ay);
            prep_next.num_y = prep_next.m - MAG_W'(ax);
        end else begin
            prep_next.num_x = MAG_W'(ax);
            prep_next.num_y = MAG_W'(ay);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule
`default_nettype wire

/* rtl/core/onp_div_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onp_div_lane
// One divider lane: forms the rounding dividend 65534*num + m and divisor
// 2*m, then a restoring divide with one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module onp_div_lane (
    input  wire logic                aclk,
    input  wire onp_pkg::pipe_ctl_t  ctl,
    input  wire onp_pkg::lane_in_t   lane_in,
    output onp_pkg::lane_res_t       res
);
    import onp_pkg::*;

    logic [N_W-1:0]  dividend;

    // Remainder, pending dividend bits and divisor for all but the last stage
    logic [R_W-1:0]  r_reg    [Q_W];
    logic [R_W-1:0]  r_next   [Q_W];
    logic [Q_W-1:0]  nlo_reg  [Q_W];
    logic [Q_W-1:0]  nlo_next [Q_W];
    logic [D_W-1:0]  d_reg    [Q_W];
    logic [D_W-1:0]  d_next   [Q_W];

    // Quotient and flags for every stage
    logic [Q_W-1:0]  q_reg     [LANE_STAGES];
    logic [Q_W-1:0]  q_next    [LANE_STAGES];
    logic            neg_reg   [LANE_STAGES];
    logic            neg_next  [LANE_STAGES];
    logic            zero_reg  [LANE_STAGES];
    logic            zero_next [LANE_STAGES];

    logic [R_W:0]    trial [1:Q_W];
    logic            ge    [1:Q_W];

    // Setup stage: dividend split so the leading part is below the divisor
    always_comb begin
        dividend = (N_W'(lane_in.num) << SCALE_W) - (N_W'(lane_in.num) << 1)
                 + N_W'(lane_in.m);
        r_next[0]    = dividend[N_W-1:Q_W];
        nlo_next[0]  = dividend[Q_W-1:0];
        d_next[0]    = {lane_in.m, 1'b0};
        q_next[0]    = '0;
        neg_next[0]  = lane_in.neg;
        zero_next[0] = lane_in.zero;

        // Quotient stages: shift in one dividend bit, compare, subtract
        for (int j = 1; j < LANE_STAGES; j++) begin
            trial[j]     = {r_reg[j-1], nlo_reg[j-1][Q_W-1]};
            ge[j]        = (trial[j] >= {1'b0, d_reg[j-1]});
            q_next[j]    = {q_reg[j-1][Q_W-2:0], ge[j]};
            neg_next[j]  = neg_reg[j-1];
            zero_next[j] = zero_reg[j-1];
        end
        for (int j = 1; j < Q_W; j++) begin
            r_next[j]   = ge[j] ? R_W'(trial[j] - {1'b0, d_reg[j-1]}) : R_W'(trial[j]);
            nlo_next[j] = {nlo_reg[j-1][Q_W-2:0], 1'b0};
            d_next[j]   = d_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < LANE_STAGES; j++) begin
            if (ctl.en[PREP_STAGES+j]) begin
                q_reg[j]    <= q_next[j];
                neg_reg[j]  <= neg_next[j];
                zero_reg[j] <= zero_next[j];
            end
        end
        for (int j = 0; j < Q_W; j++) begin
            if (ctl.en[PREP_STAGES+j]) begin
                r_reg[j]   <= r_next[j];
                nlo_reg[j] <= nlo_next[j];
                d_reg[j]   <= d_next[j];
            end
        end
    end

    assign res.q    = q_reg[LANE_STAGES-1];
    assign res.neg  = neg_reg[LANE_STAGES-1];
    assign res.zero = zero_reg[LANE_STAGES-1];

endmodule
`default_nettype wire

/* rtl/core/onp_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onp_merge
// Output register: signs the four lane quotients, applies the zero-vector
// rule and puts the bitangent flag in the low bit of the tangent x.
// ----------------------------------------------------------------------------
module onp_merge (
    input  wire logic                       aclk,
    input  wire onp_pkg::pipe_ctl_t         ctl,
    input  wire onp_pkg::lane_res_t         res_nx,
    input  wire onp_pkg::lane_res_t         res_ny,
    input  wire onp_pkg::lane_res_t         res_tx,
    input  wire onp_pkg::lane_res_t         res_ty,
    input  wire logic                       flag,
    output logic [onp_pkg::OUT_W-1:0]       enc_normal_x,
    output logic [onp_pkg::OUT_W-1:0]       enc_normal_y,
    output logic [onp_pkg::OUT_W-1:0]       enc_tangent_x,
    output logic [onp_pkg::OUT_W-1:0]       enc_tangent_y
);
    import onp_pkg::*;

    logic [OUT_W-1:0] nx_reg;
    logic [OUT_W-1:0] ny_reg;
    logic [OUT_W-1:0] tx_reg;
    logic [OUT_W-1:0] ty_reg;
    logic [OUT_W-1:0] nx_next;
    logic [OUT_W-1:0] ny_next;
    logic [OUT_W-1:0] tx_next;
    logic [OUT_W-1:0] ty_next;
    logic [OUT_W-1:0] tx_full;

    // Format the lanes; tangent x low bit carries the bitangent sign
    always_comb begin
        nx_next = snorm_value(res_nx);
        ny_next = snorm_value(res_ny);
        tx_full = snorm_value(res_tx);
        tx_next = {tx_full[OUT_W-1:1], flag};
        ty_next = snorm_value(res_ty);
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

    assign enc_normal_x  = nx_reg;
    assign enc_normal_y  = ny_reg;
    assign enc_tangent_x = tx_reg;
    assign enc_tangent_y = ty_reg;

endmodule
`default_nettype wire

/* rtl/core/octahedral_normal_tangent_pack_top.sv */
// Pipeline: 1 vector setup stage, 1 dividend setup stage, 15 quotient stages,
//   1 output register. Throughput: one item per cycle when the output is not stalled;
//   each of the four divider lanes retires one quotient bit per stage, so
//   every stage holds a different item.
// Reset: aresetn is synchronous, active low; it clears all stage valid bits
//   and the output valid. Payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octahedral_normal_tangent_pack_top
// Packs a normal and a tangent into octahedral snorm16 pairs with the
// bitangent sign in the low bit of the tangent x. Four divider lanes run in
// lockstep; the stage valid chain lets bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
module octahedral_normal_tangent_pack_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [onp_pkg::IN_BITS-1:0]  s_normal_x,
    input  wire logic [onp_pkg::IN_BITS-1:0]  s_normal_y,
    input  wire logic [onp_pkg::IN_BITS-1:0]  s_normal_z,
    input  wire logic [onp_pkg::IN_BITS-1:0]  s_tangent_x,
    input  wire logic [onp_pkg::IN_BITS-1:0]  s_tangent_y,
    input  wire logic [onp_pkg::IN_BITS-1:0]  s_tangent_z,
    input  wire logic                         s_negative_bitangent,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [onp_pkg::OUT_W-1:0]         m_enc_normal_x,
    output logic [onp_pkg::OUT_W-1:0]         m_enc_normal_y,
    output logic [onp_pkg::OUT_W-1:0]         m_enc_tangent_x,
    output logic [onp_pkg::OUT_W-1:0]         m_enc_tangent_y
);
    import onp_pkg::*;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [NSTG:0]   rdy;
    logic            flag_reg  [NSTG];
    logic            flag_next [NSTG];
    pipe_ctl_t       ctl;

    vec_prep_t       prep_n;
    vec_prep_t       prep_t;
    lane_in_t        in_nx;
    lane_in_t        in_ny;
    lane_in_t        in_tx;
    lane_in_t        in_ty;
    lane_res_t       res_nx;
    lane_res_t       res_ny;
    lane_res_t       res_tx;
    lane_res_t       res_ty;

    // Stage ready chain: a stage loads when empty or when it moves on
    always_comb begin
        rdy[NSTG] = !out_valid_reg || m_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        ctl.en       = rdy[NSTG-1:0];
        ctl.out_load = rdy[NSTG];
    end

    // Valid bits and the bitangent flag travel alongside the lanes
    always_comb begin
        v_next[0]    = rdy[0] ? s_valid : v_reg[0];
        flag_next[0] = s_negative_bitangent;
        for (int k = 1; k < NSTG; k++) begin
            v_next[k]    = rdy[k] ? v_reg[k-1] : v_reg[k];
            flag_next[k] = flag_reg[k-1];
        end
        out_valid_next = rdy[NSTG] ? v_reg[NSTG-1] : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                flag_reg[k] <= flag_next[k];
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = out_valid_reg;

    // Vector setup
    onp_vec_prep u_prep_normal (
        .aclk   (aclk),
        .ctl    (ctl),
        .comp_x (s_normal_x),
        .comp_y (s_normal_y),
        .comp_z (s_normal_z),
        .prep   (prep_n)
    );

    onp_vec_prep u_prep_tangent (
        .aclk   (aclk),
        .ctl    (ctl),
        .comp_x (s_tangent_x),
        .comp_y (s_tangent_y),
        .comp_z (s_tangent_z),
        .prep   (prep_t)
    );

    // Lane inputs: one lane per encoded component
    always_comb begin
        in_nx = '{num: prep_n.num_x, m: prep_n.m, neg: prep_n.sx, zero: prep_n.zero};
        in_ny = '{num: prep_n.num_y, m: prep_n.m, neg: prep_n.sy, zero: prep_n.zero};
        in_tx = '{num: prep_t.num_x, m: prep_t.m, neg: prep_t.sx, zero: prep_t.zero};
        in_ty = '{num: prep_t.num_y, m: prep_t.m, neg: prep_t.sy, zero: prep_t.zero};
    end

    onp_div_lane u_lane_nx (.aclk(aclk), .ctl(ctl), .lane_in(in_nx), .res(res_nx));
    onp_div_lane u_lane_ny (.aclk(aclk), .ctl(ctl), .lane_in(in_ny), .res(res_ny));
    onp_div_lane u_lane_tx (.aclk(aclk), .ctl(ctl), .lane_in(in_tx), .res(res_tx));
    onp_div_lane u_lane_ty (.aclk(aclk), .ctl(ctl), .lane_in(in_ty), .res(res_ty));

    // Merge and output register
    onp_merge u_merge (
        .aclk          (aclk),
        .ctl           (ctl),
        .res_nx        (res_nx),
        .res_ny        (res_ny),
        .res_tx        (res_tx),
        .res_ty        (res_ty),
        .flag          (flag_reg[NSTG-1]),
        .enc_normal_x  (m_enc_normal_x),
        .enc_normal_y  (m_enc_normal_y),
        .enc_tangent_x (m_enc_tangent_x),
        .enc_tangent_y (m_enc_tangent_y)
    );

`ifndef ASSERT_OFF
    // An empty setup stage must always take a new item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[0] |-> s_ready)
        else $error("input not ready with empty setup stage");

    // Full pipeline behind a stalled output must hold off the input
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && (&v_reg)) |-> !s_ready)
        else $error("input ready while pipeline full and stalled");

    // Quotient never exceeds 32767, so the most negative code never appears in normal x/y or tangent y
    a_no_min_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_enc_normal_x != 16'h8000) && (m_enc_normal_y != 16'h8000)
                    && (m_enc_tangent_y != 16'h8000))
        else $error("encoded component out of snorm16 range");

    // A result appears only if an item sat in the last lane stage
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v_reg[NSTG-1]))
        else $error("result without item in last stage");
`endif

endmodule
`default_nettype wire
